/* design/grnw_pkg.sv */
// ----------------------------------------------------------------------------
// grnw_pkg
// Shared constants and types for the grid ray caster: fixed-point formats,
// sine series constants and internal datapath widths.
// ----------------------------------------------------------------------------
package grnw_pkg;

    // Fixed-point formats
    localparam int FRAC_W    = 8;          // fraction bits of positions
    localparam int SIN_W     = 16;         // signed Q1.14 sine/cosine
    localparam int ROW_BITS  = 32;         // wall bits per map word
    localparam int COL_W     = 5;          // bit select within a map word

    // Sine series (quarter wave, Q30)
    localparam logic [14:0] QUARTER    = 15'd16384;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [3:0]  SIN_TERMS  = 4'd12;
    localparam logic signed [SIN_W-1:0] SIN_ONE = 16'sd16384;

    // Datapath widths, sized for the largest map and tile settings
    localparam int NUM_W     = 24;         // signed line minus origin
    localparam int DIVD_W    = 37;         // dividend of the shared divider
    localparam int DIVS_W    = 15;         // divisor of the shared divider
    localparam int DCNT_W    = 6;          // divider step counter
    localparam int T_W       = 37;         // ray parameter t, Q.8
    localparam int P_W       = 40;         // signed crossing coordinate
    localparam int MUL_A_W   = 37;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // Output saturation limits
    localparam logic [19:0] DIST_MAX = 20'd1048575;
    localparam logic [18:0] HX_MAX   = 19'd524287;
    localparam logic [17:0] HY_MAX   = 18'd262143;

    // Request opcodes
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_CAST = 1'b1
    } t_func;

endpackage

/* design/grid_raycast_nearest_wall_top.sv */
// A load request writes its map word without leaving idle. A cast builds
// sin and cos from a series of x and 12 further terms, then visits each
// grid line (MAP_ROWS + MAP_COLS + 2 lines).
// One request at a time; the shared 37-step restoring divider serves both
// the series and the line scan. Reset (synchronous, active low) clears
// the map row valid bits, so every map word reads as no walls.
// ----------------------------------------------------------------------------
// grid_raycast_nearest_wall_top
// Keeps a one-bit wall map and casts rays against its grid lines, returning
// the nearest wall crossing. One shared multiplier and one shared divider
// are stepped by a small sequencer.
// ----------------------------------------------------------------------------
module grid_raycast_nearest_wall_top
    import grnw_pkg::*;
#(
    parameter int MAP_ROWS   = 16,
    parameter int MAP_COLS   = 32,
    parameter int TILE_SHIFT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [3:0]  i_row_index,
    input  logic [31:0] i_row_walls,
    input  logic [18:0] i_origin_x,
    input  logic [17:0] i_origin_y,
    input  logic [15:0] i_ray_angle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_wall_hit,
    output logic [19:0] o_distance,
    output logic [18:0] o_hit_x,
    output logic [17:0] o_hit_y
);

    localparam int ROW_W     = $clog2(MAP_ROWS);
    localparam int MAX_LINES = (MAP_ROWS > MAP_COLS) ? MAP_ROWS : MAP_COLS;
    localparam int IDX_W     = $clog2(MAX_LINES + 1);
    localparam int SHIFT     = TILE_SHIFT + FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIN_INIT,
        S_SIN_M1,
        S_SIN_M2,
        S_SIN_DIV,
        S_SIN_END,
        S_LINE_SETUP,
        S_LINE_DIV,
        S_LINE_MUL,
        S_LINE_RD,
        S_LINE_CHK,
        S_DONE
    } t_state;

    t_state r_state;

    // request registers
    logic [18:0] r_ox;
    logic [17:0] r_oy;
    logic [13:0] r_off;
    logic [1:0]  r_quad;
    logic        r_down, r_right;

    // sine series
    logic        r_cos_pass;
    logic [30:0] r_x;
    logic [32:0] r_term;
    logic [31:0] r_sum;
    logic [3:0]  r_n;
    logic [31:0] r_mtmp;
    logic signed [SIN_W-1:0] r_sin, r_cos;

    // line scan
    logic             r_vert;
    logic [IDX_W-1:0] r_idx;
    logic [T_W-1:0]   r_t;
    logic signed [P_W-1:0] r_p;
    logic             r_cell_ok;
    logic [COL_W-1:0] r_col;
    logic             r_found;
    logic [T_W-1:0]   r_best_t;
    logic [P_W-1:0]   r_bx, r_by;

    // shared divider
    logic [DIVS_W-1:0] r_div_rem;
    logic [DIVD_W-1:0] r_div_quo;
    logic [DIVS_W-1:0] r_div_dvs;
    logic [DCNT_W-1:0] r_div_cnt;

    // map store
    logic [ROW_BITS-1:0] r_map [MAP_ROWS];
    logic [MAP_ROWS-1:0] r_row_vld;
    logic [ROW_BITS-1:0] r_rd_row;
    logic                r_rd_vld;

    logic accept, load_wr;
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign load_wr = accept && (t_func'(i_func) == FUNC_LOAD)
                     && (32'(i_row_index) < MAP_ROWS);

    // ROM address of the current sine pass (cos is sin a quarter turn on)
    logic [1:0]  quad_eff;
    logic [14:0] rom_k;
    assign quad_eff = r_quad + {1'b0, r_cos_pass};
    assign rom_k    = quad_eff[0] ? (QUARTER - {1'b0, r_off}) : {1'b0, r_off};

    // series divisor (2n)(2n+1)
    logic [4:0] n2;
    logic [9:0] sin_dvs;
    assign n2      = {r_n, 1'b0};
    assign sin_dvs = 10'(n2) * 10'(n2 + 5'd1);

    // line operands
    logic signed [NUM_W-1:0] line_v, org_a, num;
    logic signed [SIN_W-1:0] d_v, pd_v;
    logic [NUM_W-2:0]        un;
    logic [DIVS_W-1:0]       ud, abs_pd;
    logic [18:0]             po_u;
    logic                    skip;
    assign line_v = NUM_W'(r_idx) << SHIFT;
    assign org_a  = r_vert ? NUM_W'(r_ox) : NUM_W'(r_oy);
    assign num    = line_v - org_a;
    assign d_v    = r_vert ? r_cos : r_sin;
    assign pd_v   = r_vert ? r_sin : r_cos;
    assign po_u   = r_vert ? {1'b0, r_oy} : r_ox;
    assign un     = num[NUM_W-1] ? (NUM_W-1)'(-num) : (NUM_W-1)'(num);
    assign ud     = d_v[SIN_W-1] ? DIVS_W'(-d_v) : DIVS_W'(d_v);
    assign abs_pd = pd_v[SIN_W-1] ? DIVS_W'(-pd_v) : DIVS_W'(pd_v);
    assign skip   = (d_v == '0) || ((num != '0) && (num[NUM_W-1] != d_v[SIN_W-1]));

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    always_comb begin
        unique case (r_state)
            S_SIN_INIT: begin
                mul_a = MUL_A_W'(rom_k);
                mul_b = PI_Q30;
            end
            S_SIN_M1: begin
                mul_a = MUL_A_W'(r_term);
                mul_b = MUL_B_W'(r_x);
            end
            S_SIN_M2: begin
                mul_a = MUL_A_W'(r_mtmp);
                mul_b = MUL_B_W'(r_x);
            end
            S_LINE_MUL: begin
                mul_a = MUL_A_W'(r_div_quo);
                mul_b = MUL_B_W'(abs_pd);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // series helpers
    logic [46:0] x_sum;
    logic [30:0] x_v;
    logic [32:0] mag_sum;
    logic [15:0] mag;
    logic signed [SIN_W-1:0] sin_val;
    assign x_sum   = mul_p[46:0] + 47'd16384;
    assign x_v     = x_sum[45:15];
    assign mag_sum = {1'b0, r_sum} + 33'd32768;
    assign mag     = mag_sum[31:16];
    assign sin_val = quad_eff[1] ? -$signed(mag) : $signed(mag);

    // crossing coordinate: origin plus rounded t * component
    logic [MUL_P_W-1:0]    rnd;
    logic signed [P_W-1:0] r_mag, po_s, p_v;
    assign rnd   = mul_p + MUL_P_W'(8192);
    assign r_mag = P_W'(rnd >> 14);
    assign po_s  = P_W'(po_u);
    assign p_v   = pd_v[SIN_W-1] ? (po_s - r_mag) : (po_s + r_mag);

    // tile beside the crossing
    logic signed [P_W-1:0] tile, idx_s, idx_m1, cell_row, cell_col;
    logic                  cell_ok;
    logic [ROW_W-1:0]      rd_addr;
    assign tile     = r_p[P_W-1] ? -P_W'(1) : (r_p >>> SHIFT);
    assign idx_s    = P_W'(r_idx);
    assign idx_m1   = idx_s - P_W'(1);
    assign cell_row = r_vert ? tile : (r_down ? idx_s : idx_m1);
    assign cell_col = r_vert ? (r_right ? idx_s : idx_m1) : tile;
    assign cell_ok  = (cell_row >= 0) && (cell_row < MAP_ROWS) && (cell_col >= 0)
                      && (cell_col < MAP_COLS) && (cell_col < ROW_BITS);
    assign rd_addr  = cell_row[ROW_W-1:0];

    // nearest-wall update
    logic wall, better;
    assign wall   = r_cell_ok && r_rd_vld && r_rd_row[r_col];
    assign better = wall && (!r_found || (r_t < r_best_t));

    // next line
    logic             last_line;
    t_state           adv_state;
    logic             adv_vert;
    logic [IDX_W-1:0] adv_idx;
    always_comb begin
        last_line = r_vert ? (r_idx == IDX_W'(MAP_COLS)) : (r_idx == IDX_W'(MAP_ROWS));
        adv_state = S_LINE_SETUP;
        adv_vert  = r_vert;
        adv_idx   = r_idx + IDX_W'(1);
        if (last_line) begin
            adv_idx = '0;
            if (r_vert) begin
                adv_state = S_DONE;
            end else begin
                adv_vert = 1'b1;
            end
        end
    end

    // divider step (restoring, one quotient bit per cycle)
    logic [DIVS_W:0]   rem_sh;
    logic              div_ge;
    logic [DIVS_W-1:0] rem_nx;
    assign rem_sh = {r_div_rem, r_div_quo[DIVD_W-1]};
    assign div_ge = rem_sh >= {1'b0, r_div_dvs};
    assign rem_nx = div_ge ? DIVS_W'(rem_sh - {1'b0, r_div_dvs}) : DIVS_W'(rem_sh);

    // map store write and registered read
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_map[ROW_W'(i_row_index)] <= i_row_walls;
        end
        if (r_state == S_LINE_RD) begin
            r_rd_row <= r_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (load_wr) begin
                r_row_vld[ROW_W'(i_row_index)] <= 1'b1;
            end
            if (r_state == S_LINE_RD) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
            o_valid   <= 1'b0;
        end else begin
            // result taken downstream; the done state sets the next one itself
            if (o_valid && !i_stall && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end

            if (r_div_cnt != '0) begin
                r_div_rem <= rem_nx;
                r_div_quo <= {r_div_quo[DIVD_W-2:0], div_ge};
                r_div_cnt <= r_div_cnt - DCNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (t_func'(i_func) == FUNC_CAST)) begin
                        r_ox       <= i_origin_x;
                        r_oy       <= i_origin_y;
                        r_off      <= i_ray_angle[13:0];
                        r_quad     <= i_ray_angle[15:14];
                        r_down     <= (i_ray_angle != '0) && !i_ray_angle[15];
                        r_right    <= (i_ray_angle < 16'd16384) || (i_ray_angle > 16'd49152);
                        r_cos_pass <= 1'b0;
                        r_state    <= S_SIN_INIT;
                    end
                end
                S_SIN_INIT: begin
                    r_x     <= x_v;
                    r_term  <= 33'(x_v);
                    r_sum   <= 32'(x_v);
                    r_n     <= 4'd1;
                    r_state <= S_SIN_M1;
                end
                S_SIN_M1: begin
                    r_mtmp  <= mul_p[61:30];
                    r_state <= S_SIN_M2;
                end
                S_SIN_M2: begin
                    r_div_quo <= DIVD_W'(mul_p[62:30]);
                    r_div_rem <= '0;
                    r_div_dvs <= DIVS_W'(sin_dvs);
                    r_div_cnt <= DCNT_W'(DIVD_W);
                    r_state   <= S_SIN_DIV;
                end
                S_SIN_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_term <= r_div_quo[32:0];
                        r_sum  <= r_n[0] ? (r_sum - r_div_quo[31:0])
                                         : (r_sum + r_div_quo[31:0]);
                        if (r_n == SIN_TERMS) begin
                            r_state <= S_SIN_END;
                        end else begin
                            r_n     <= r_n + 4'd1;
                            r_state <= S_SIN_M1;
                        end
                    end
                end
                S_SIN_END: begin
                    if (!r_cos_pass) begin
                        r_sin      <= sin_val;
                        r_cos_pass <= 1'b1;
                        r_state    <= S_SIN_INIT;
                    end else begin
                        r_cos    <= sin_val;
                        r_vert   <= 1'b0;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_best_t <= '0;
                        r_bx     <= '0;
                        r_by     <= '0;
                        r_state  <= S_LINE_SETUP;
                    end
                end
                S_LINE_SETUP: begin
                    if (skip) begin
                        r_vert  <= adv_vert;
                        r_idx   <= adv_idx;
                        r_state <= adv_state;
                    end else begin
                        r_div_quo <= {un, 14'd0};
                        r_div_rem <= '0;
                        r_div_dvs <= ud;
                        r_div_cnt <= DCNT_W'(DIVD_W);
                        r_state   <= S_LINE_DIV;
                    end
                end
                S_LINE_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_state <= S_LINE_MUL;
                    end
                end
                S_LINE_MUL: begin
                    r_t     <= r_div_quo;
                    r_p     <= p_v;
                    r_state <= S_LINE_RD;
                end
                S_LINE_RD: begin
                    r_cell_ok <= cell_ok;
                    r_col     <= cell_col[COL_W-1:0];
                    r_state   <= S_LINE_CHK;
                end
                S_LINE_CHK: begin
                    if (better) begin
                        r_found  <= 1'b1;
                        r_best_t <= r_t;
                        r_bx     <= r_vert ? P_W'(line_v) : r_p;
                        r_by     <= r_vert ? r_p : P_W'(line_v);
                    end
                    r_vert  <= adv_vert;
                    r_idx   <= adv_idx;
                    r_state <= adv_state;
                end
                S_DONE: begin
                    // hold until the previous result has left
                    if (!o_valid || !i_stall) begin
                        o_valid    <= 1'b1;
                        o_wall_hit <= r_found;
                        o_distance <= (r_best_t > T_W'(DIST_MAX)) ? DIST_MAX
                                                                  : r_best_t[19:0];
                        o_hit_x    <= (r_bx > P_W'(HX_MAX)) ? HX_MAX : r_bx[18:0];
                        o_hit_y    <= (r_by > P_W'(HY_MAX)) ? HY_MAX : r_by[17:0];
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // divider only runs while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |-> (r_state == S_SIN_DIV || r_state == S_LINE_DIV))
        else $error("divider stepping outside a divide state");

    // a miss reports all zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_wall_hit) |-> (o_distance == '0 && o_hit_x == '0 && o_hit_y == '0))
        else $error("miss result carries nonzero values");

    // series results stay within unit magnitude
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINE_SETUP) |-> (r_sin <= SIN_ONE && r_sin >= -SIN_ONE
                                       && r_cos <= SIN_ONE && r_cos >= -SIN_ONE))
        else $error("sine or cosine out of range");

    // leaving the done state always presents a result
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_DONE || o_valid))
        else $error("cast finished without a result");

endmodule
